// ===== src/blit_pkg.sv =====
// ----------------------------------------------------------------------------
// blit_pkg: shared types and constants for the rectangle blitter
// Command codes, register indexes, stream layout and coordinate helpers.
// ----------------------------------------------------------------------------
package blit_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    // configuration port
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;
    localparam logic [CFG_W-1:0]     FRAME_DIM_RST    = 9'd256;

    // input beat layout
    localparam int POS_W      = 16;
    localparam int LEN_W      = 15;
    localparam int PIX_W      = 32;
    localparam int OP_W       = 2;
    localparam int X_LSB      = 0;
    localparam int Y_LSB      = X_LSB + POS_W;
    localparam int SX_LSB     = Y_LSB + POS_W;
    localparam int SY_LSB     = SX_LSB + POS_W;
    localparam int W_LSB      = SY_LSB + POS_W;
    localparam int H_LSB      = W_LSB + LEN_W;
    localparam int C_LSB      = H_LSB + LEN_W;
    localparam int IN_BITS    = C_LSB + PIX_W;
    localparam int S_TDATA_W  = ((IN_BITS + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_FILL  = 2'd0,
        OP_COPY  = 2'd1,
        OP_READ  = 2'd2,
        OP_WRITE = 2'd3
    } op_t;

    // signed working width for clip math: covers -32768..36864
    localparam int CRD_W = 18;
    typedef logic signed [CRD_W-1:0] crd_t;

    function automatic crd_t crd_max(input crd_t a, input crd_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic crd_t crd_min(input crd_t a, input crd_t b);
        return (a < b) ? a : b;
    endfunction

endpackage

// ===== src/framebuffer_rect_fill_copy_blitter.sv =====
// ----------------------------------------------------------------------------
// framebuffer_rect_fill_copy_blitter: 2D fill / copy / pixel access engine
// Frame of 32-bit pixels in one synchronous RAM, walked one pixel a cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive on the s_ side (kind in s_tuser), one result beat per
//   command leaves on the m_ side: m_tdata is the pixel for a read (zero if
//   outside the frame or not a read), m_tuser flags a read.
//   frame_width / frame_height are written on cfg_we/cfg_addr/cfg_wdata while
//   the engine is idle; values above the maximum act as the maximum.
//   One command is in flight at a time. A read passes through the address,
//   RAM access and data steps before its result; a write skips the data step.
//   Fill and copy clip, plan and do the row-base multiply, then walk one pixel
//   per cycle through the single RAM write port; copy writes each pixel in
//   the cycle after its source read and forwards a write that hits the read address.
//   s_tready is high only between commands. A finished result sits in the
//   output register; the next command is accepted while it waits, and its own
//   result holds until the receiver takes the previous one.
//   Reset clears control state and the size registers (256 x 256); the RAM is
//   not cleared, so pixels read back only after being written.
// ----------------------------------------------------------------------------
module framebuffer_rect_fill_copy_blitter
    import blit_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // x_pos, y_pos, src_x_pos, src_y_pos, rect_width, rect_height, pixel_value
    input  logic [S_TDATA_W-1:0] s_tdata,
    // op
    input  logic [OP_W-1:0]      s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // read_value
    output logic [PIX_W-1:0]     m_tdata,
    // read_valid
    output logic                 m_tuser,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    localparam int FW_W   = $clog2(MAX_WIDTH + 1);
    localparam int FH_W   = $clog2(MAX_HEIGHT + 1);
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PROD_W = ROW_W + FW_W;

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b00_0000_0001,
        ST_PIX      = 10'b00_0000_0010,
        ST_PIX_ACC  = 10'b00_0000_0100,
        ST_PIX_DATA = 10'b00_0000_1000,
        ST_CLIP     = 10'b00_0001_0000,
        ST_PLAN     = 10'b00_0010_0000,
        ST_BASE     = 10'b00_0100_0000,
        ST_WALK     = 10'b00_1000_0000,
        ST_DRAIN    = 10'b01_0000_0000,
        ST_RESP     = 10'b10_0000_0000
    } state_t;

    // control
    state_t              state_reg, state_next;
    logic [CFG_W-1:0]    fwidth_reg, fwidth_next;
    logic [CFG_W-1:0]    fheight_reg, fheight_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic                pipe_vld_reg, pipe_vld_next;

    // payload
    op_t                 op_reg, op_next;
    logic signed [POS_W-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [POS_W-1:0] sx_reg, sx_next, sy_reg, sy_next;
    logic [LEN_W-1:0]    w_reg, w_next, h_reg, h_next;
    logic [PIX_W-1:0]    color_reg, color_next;
    logic [PIX_W-1:0]    res_value_reg, res_value_next;
    logic                res_rd_reg, res_rd_next;
    logic [PIX_W-1:0]    m_tdata_reg, m_tdata_next;
    logic                m_tuser_reg, m_tuser_next;
    logic                pix_in_reg, pix_in_next;
    logic [ADDR_W-1:0]   pix_addr_reg, pix_addr_next;
    crd_t                r0_reg, r0_next, r1_reg, r1_next;
    crd_t                c0_reg, c0_next, c1_reg, c1_next;
    logic                rows_up_reg, rows_up_next, cols_up_reg, cols_up_next;
    logic [ROW_W-1:0]    srow_reg, srow_next, drow_reg, drow_next;
    logic [ROW_W-1:0]    row_left_reg, row_left_next;
    logic [COL_W-1:0]    col_left_reg, col_left_next, col_last_reg, col_last_next;
    logic [COL_W-1:0]    scol_st_reg, scol_st_next, dcol_st_reg, dcol_st_next;
    logic [COL_W-1:0]    scol_reg, scol_next, dcol_reg, dcol_next;
    logic [ADDR_W-1:0]   sbase_reg, sbase_next, dbase_reg, dbase_next;
    logic [ADDR_W-1:0]   pipe_addr_reg, pipe_addr_next;

    // memory
    logic [PIX_W-1:0]    frame_mem [DEPTH];
    logic [PIX_W-1:0]    rd_data_reg;
    logic                fwd_hit_reg;
    logic [PIX_W-1:0]    fwd_data_reg;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
    logic [PIX_W-1:0]    mem_wdata, mem_rdata;

    // datapath helpers
    logic [FW_W-1:0]     fw;
    logic [FH_W-1:0]     fh;
    crd_t                fw_s, fh_s;
    crd_t                dx_e, dy_e, sx_e, sy_e, w_e, h_e;
    crd_t                r_st, c_st;
    logic                rect_empty, pix_inside;
    logic [ROW_W-1:0]    mul_row;
    logic [PROD_W-1:0]   sprod, dprod;
    logic [ADDR_W-1:0]   fw_a, s_addr, d_addr;
    op_t                 in_op;

    assign fw = (32'(fwidth_reg) > 32'(MAX_WIDTH)) ? FW_W'(MAX_WIDTH) : FW_W'(fwidth_reg);
    assign fh = (32'(fheight_reg) > 32'(MAX_HEIGHT)) ? FH_W'(MAX_HEIGHT) : FH_W'(fheight_reg);
    assign fw_s = $signed({{(CRD_W-FW_W){1'b0}}, fw});
    assign fh_s = $signed({{(CRD_W-FH_W){1'b0}}, fh});
    assign fw_a = ADDR_W'(fw);

    assign dx_e = CRD_W'(x_reg);
    assign dy_e = CRD_W'(y_reg);
    assign sx_e = CRD_W'(sx_reg);
    assign sy_e = CRD_W'(sy_reg);
    assign w_e  = $signed({{(CRD_W-LEN_W){1'b0}}, w_reg});
    assign h_e  = $signed({{(CRD_W-LEN_W){1'b0}}, h_reg});

    assign rect_empty = (r0_reg >= r1_reg) || (c0_reg >= c1_reg);
    assign r_st = (dy_e <= sy_e) ? r0_reg : r1_reg - CRD_W'(1);
    assign c_st = (dx_e <= sx_e) ? c0_reg : c1_reg - CRD_W'(1);

    assign pix_inside = (dx_e >= 0) && (dx_e < fw_s) && (dy_e >= 0) && (dy_e < fh_s);

    // one row multiplier shared by pixel access and the source row base
    assign mul_row = (state_reg == ST_PIX) ? y_reg[ROW_W-1:0] : srow_reg;
    assign sprod = {{FW_W{1'b0}}, mul_row} * {{ROW_W{1'b0}}, fw};
    assign dprod = {{FW_W{1'b0}}, drow_reg} * {{ROW_W{1'b0}}, fw};

    assign s_addr = sbase_reg + ADDR_W'(scol_reg);
    assign d_addr = dbase_reg + ADDR_W'(dcol_reg);

    assign in_op = op_t'(s_tuser);

    assign mem_rdata = fwd_hit_reg ? fwd_data_reg : rd_data_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb
    begin
        state_next     = state_reg;
        fwidth_next    = fwidth_reg;
        fheight_next   = fheight_reg;
        m_tvalid_next  = m_tvalid_reg;
        pipe_vld_next  = 1'b0;
        op_next        = op_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        w_next         = w_reg;
        h_next         = h_reg;
        color_next     = color_reg;
        res_value_next = res_value_reg;
        res_rd_next    = res_rd_reg;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;
        pix_in_next    = pix_in_reg;
        pix_addr_next  = pix_addr_reg;
        r0_next        = r0_reg;
        r1_next        = r1_reg;
        c0_next        = c0_reg;
        c1_next        = c1_reg;
        rows_up_next   = (dy_e <= sy_e);
        cols_up_next   = (dx_e <= sx_e);
        srow_next      = srow_reg;
        drow_next      = drow_reg;
        row_left_next  = row_left_reg;
        col_left_next  = col_left_reg;
        col_last_next  = col_last_reg;
        scol_st_next   = scol_st_reg;
        dcol_st_next   = dcol_st_reg;
        scol_next      = scol_reg;
        dcol_next      = dcol_reg;
        sbase_next     = sbase_reg;
        dbase_next     = dbase_reg;
        pipe_addr_next = d_addr;
        mem_we         = 1'b0;
        mem_waddr      = d_addr;
        mem_wdata      = color_reg;
        mem_raddr      = s_addr;

        if (cfg_we)
        begin
            case (cfg_addr)
                REG_FRAME_WIDTH:  fwidth_next  = cfg_wdata;
                REG_FRAME_HEIGHT: fheight_next = cfg_wdata;
                default: ;
            endcase
        end

        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;

        // copy write-back, in the cycle after its source read
        if (pipe_vld_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = pipe_addr_reg;
            mem_wdata = mem_rdata;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next        = in_op;
                    x_next         = s_tdata[X_LSB +: POS_W];
                    y_next         = s_tdata[Y_LSB +: POS_W];
                    // fill runs through the copy walker with source = destination
                    sx_next        = (in_op == OP_FILL) ? s_tdata[X_LSB +: POS_W]
                                                        : s_tdata[SX_LSB +: POS_W];
                    sy_next        = (in_op == OP_FILL) ? s_tdata[Y_LSB +: POS_W]
                                                        : s_tdata[SY_LSB +: POS_W];
                    w_next         = s_tdata[W_LSB +: LEN_W];
                    h_next         = s_tdata[H_LSB +: LEN_W];
                    color_next     = s_tdata[C_LSB +: PIX_W];
                    res_value_next = '0;
                    res_rd_next    = (in_op == OP_READ);
                    if (in_op inside {OP_FILL, OP_COPY})
                        state_next = ST_CLIP;
                    else
                        state_next = ST_PIX;
                end
            end

            ST_PIX:
            begin
                pix_in_next   = pix_inside;
                pix_addr_next = ADDR_W'(sprod) + ADDR_W'(x_reg[COL_W-1:0]);
                state_next    = ST_PIX_ACC;
            end

            ST_PIX_ACC:
            begin
                mem_raddr = pix_addr_reg;
                if ((op_reg == OP_WRITE) && pix_in_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = pix_addr_reg;
                    mem_wdata = color_reg;
                end
                state_next = (op_reg == OP_READ) ? ST_PIX_DATA : ST_RESP;
            end

            ST_PIX_DATA:
            begin
                res_value_next = pix_in_reg ? mem_rdata : '0;
                state_next     = ST_RESP;
            end

            ST_CLIP:
            begin
                // offsets where source and destination both lie in the frame
                r0_next    = crd_max(CRD_W'(0), crd_max(-sy_e, -dy_e));
                r1_next    = crd_min(h_e, crd_min(fh_s - sy_e, fh_s - dy_e));
                c0_next    = crd_max(CRD_W'(0), crd_max(-sx_e, -dx_e));
                c1_next    = crd_min(w_e, crd_min(fw_s - sx_e, fw_s - dx_e));
                state_next = ST_PLAN;
            end

            ST_PLAN:
            begin
                if (rect_empty)
                    state_next = ST_RESP;
                else
                begin
                    srow_next     = ROW_W'(sy_e + r_st);
                    drow_next     = ROW_W'(dy_e + r_st);
                    scol_st_next  = COL_W'(sx_e + c_st);
                    dcol_st_next  = COL_W'(dx_e + c_st);
                    scol_next     = COL_W'(sx_e + c_st);
                    dcol_next     = COL_W'(dx_e + c_st);
                    row_left_next = ROW_W'(r1_reg - r0_reg - CRD_W'(1));
                    col_last_next = COL_W'(c1_reg - c0_reg - CRD_W'(1));
                    col_left_next = COL_W'(c1_reg - c0_reg - CRD_W'(1));
                    state_next    = ST_BASE;
                end
            end

            ST_BASE:
            begin
                sbase_next = ADDR_W'(sprod);
                dbase_next = ADDR_W'(dprod);
                state_next = ST_WALK;
            end

            ST_WALK:
            begin
                if (op_reg == OP_FILL)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = d_addr;
                    mem_wdata = color_reg;
                end
                else
                begin
                    pipe_vld_next  = 1'b1;
                    pipe_addr_next = d_addr;
                end

                if (col_left_reg == '0)
                begin
                    col_left_next = col_last_reg;
                    scol_next     = scol_st_reg;
                    dcol_next     = dcol_st_reg;
                    sbase_next    = rows_up_reg ? sbase_reg + fw_a : sbase_reg - fw_a;
                    dbase_next    = rows_up_reg ? dbase_reg + fw_a : dbase_reg - fw_a;
                    row_left_next = row_left_reg - ROW_W'(1);
                    if (row_left_reg == '0)
                        state_next = (op_reg == OP_COPY) ? ST_DRAIN : ST_RESP;
                end
                else
                begin
                    col_left_next = col_left_reg - COL_W'(1);
                    scol_next     = cols_up_reg ? scol_reg + COL_W'(1) : scol_reg - COL_W'(1);
                    dcol_next     = cols_up_reg ? dcol_reg + COL_W'(1) : dcol_reg - COL_W'(1);
                end
            end

            ST_DRAIN:
            begin
                state_next = ST_RESP;
            end

            ST_RESP:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_value_reg;
                    m_tuser_next  = res_rd_reg;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // direction flags only matter once the walk is planned
        if (state_reg != ST_PLAN)
        begin
            rows_up_next = rows_up_reg;
            cols_up_next = cols_up_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            fwidth_reg   <= FRAME_DIM_RST;
            fheight_reg  <= FRAME_DIM_RST;
            m_tvalid_reg <= 1'b0;
            pipe_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fwidth_reg   <= fwidth_next;
            fheight_reg  <= fheight_next;
            m_tvalid_reg <= m_tvalid_next;
            pipe_vld_reg <= pipe_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        sx_reg        <= sx_next;
        sy_reg        <= sy_next;
        w_reg         <= w_next;
        h_reg         <= h_next;
        color_reg     <= color_next;
        res_value_reg <= res_value_next;
        res_rd_reg    <= res_rd_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
        pix_in_reg    <= pix_in_next;
        pix_addr_reg  <= pix_addr_next;
        r0_reg        <= r0_next;
        r1_reg        <= r1_next;
        c0_reg        <= c0_next;
        c1_reg        <= c1_next;
        rows_up_reg   <= rows_up_next;
        cols_up_reg   <= cols_up_next;
        srow_reg      <= srow_next;
        drow_reg      <= drow_next;
        row_left_reg  <= row_left_next;
        col_left_reg  <= col_left_next;
        col_last_reg  <= col_last_next;
        scol_st_reg   <= scol_st_next;
        dcol_st_reg   <= dcol_st_next;
        scol_reg      <= scol_next;
        dcol_reg      <= dcol_next;
        sbase_reg     <= sbase_next;
        dbase_reg     <= dbase_next;
        pipe_addr_reg <= pipe_addr_next;
    end

    // frame RAM: one write port, one registered read port, write-first bypass
    always_ff @(posedge clk)
    begin
        if (mem_we)
            frame_mem[mem_waddr] <= mem_wdata;
        rd_data_reg  <= frame_mem[mem_raddr];
        fwd_hit_reg  <= mem_we && (mem_waddr == mem_raddr);
        fwd_data_reg <= mem_wdata;
    end

endmodule

// ===== src/blit_chk.sv =====
// ----------------------------------------------------------------------------
// blit_chk: port-level checks for the rectangle blitter
// Watches the command and result streams over time.
// ----------------------------------------------------------------------------
module blit_chk
    import blit_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [PIX_W-1:0] m_tdata,
    input logic             m_tuser
);

    // a stalled result beat holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // only one command in flight: intake closes right after a beat
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command accepted while another is in flight");

    // non-read results carry zero data
    a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("non-read result with nonzero data");

    // a result only appears when the engine was busy finishing a command
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result raised while engine idle");

endmodule

bind framebuffer_rect_fill_copy_blitter blit_chk u_blit_chk (.*);

// ===== dv/blit_result_checker.sv =====
// ----------------------------------------------------------------------------
// blit_result_checker: result predictor and comparator for the blitter
// Mirrors the frame store and size registers from the observed command and
// config traffic, queues one expected result beat per accepted command and
// checks every result beat against the oldest entry, field by field.
// ----------------------------------------------------------------------------
module blit_result_checker
    import blit_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [OP_W-1:0]      s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [PIX_W-1:0]     m_tdata,
    input  logic                 m_tuser,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata,
    output int                   errors,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic             is_read;
    } px_result_t;

    bit [PIX_W-1:0]   shadow_fb [DEF_MAX_WIDTH*DEF_MAX_HEIGHT];
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    px_result_t       result_q[$];
    int               fail_cnt;
    int               beat_no;

    task automatic report_error(input string msg);
        $display("[%0t] ERROR beat %0d: %s", $realtime, beat_no, msg);
        fail_cnt++;
    endtask

    function automatic int frame_cols();
        return (width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(width_reg);
    endfunction

    function automatic int frame_rows();
        return (height_reg > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(height_reg);
    endfunction

    function automatic void fill_rect(input int x, input int y, input int w, input int h,
                                      input logic [PIX_W-1:0] c);
        int fw, fh, xa, xb, ya, yb;
        fw = frame_cols();
        fh = frame_rows();
        xa = (x > 0) ? x : 0;
        ya = (y > 0) ? y : 0;
        xb = (x + w < fw) ? x + w : fw;
        yb = (y + h < fh) ? y + h : fh;
        for (int py = ya; py < yb; py++)
            for (int px = xa; px < xb; px++)
                shadow_fb[py*fw + px] = c;
    endfunction

    function automatic void copy_rect(input int sx, input int sy, input int dx, input int dy,
                                      input int w, input int h);
        int fw, fh, r0, r1, c0, c1, r, c;
        bit rows_up, cols_up;
        fw = frame_cols();
        fh = frame_rows();
        if (w <= 0 || h <= 0)
            return;
        // offsets where source and destination both land inside the frame
        r0 = 0;
        if (-sy > r0) r0 = -sy;
        if (-dy > r0) r0 = -dy;
        r1 = h;
        if (fh - sy < r1) r1 = fh - sy;
        if (fh - dy < r1) r1 = fh - dy;
        c0 = 0;
        if (-sx > c0) c0 = -sx;
        if (-dx > c0) c0 = -dx;
        c1 = w;
        if (fw - sx < c1) c1 = fw - sx;
        if (fw - dx < c1) c1 = fw - dx;
        if (r0 >= r1 || c0 >= c1)
            return;
        // walk away from the overlap so no source pixel is clobbered early
        rows_up = (dy <= sy);
        cols_up = (dx <= sx);
        for (int i = 0; i < r1 - r0; i++)
        begin
            r = rows_up ? r0 + i : r1 - 1 - i;
            for (int j = 0; j < c1 - c0; j++)
            begin
                c = cols_up ? c0 + j : c1 - 1 - j;
                shadow_fb[(dy + r)*fw + dx + c] = shadow_fb[(sy + r)*fw + sx + c];
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        px_result_t want;
        logic [S_TDATA_W-1:0] d;
        int x, y, fw, fh;
        if (!rst_n)
        begin
            width_reg  = FRAME_DIM_RST;
            height_reg = FRAME_DIM_RST;
            result_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_addr == REG_FRAME_WIDTH)
                    width_reg = cfg_wdata;
                else if (cfg_addr == REG_FRAME_HEIGHT)
                    height_reg = cfg_wdata;
            end

            // retire first: a waiting result may leave as the next command enters
            if (m_tvalid && m_tready)
            begin
                if (result_q.size() == 0)
                    report_error($sformatf("unexpected beat data %h flag %b", m_tdata, m_tuser));
                else
                begin
                    want = result_q.pop_front();
                    if (m_tdata !== want.value)
                        report_error($sformatf("read_value got %h expected %h",
                                               m_tdata, want.value));
                    if (m_tuser !== want.is_read)
                        report_error($sformatf("read_valid got %b expected %b",
                                               m_tuser, want.is_read));
                end
                beat_no++;
            end

            if (s_tvalid && s_tready)
            begin
                d  = s_tdata;
                x  = $signed(d[X_LSB +: POS_W]);
                y  = $signed(d[Y_LSB +: POS_W]);
                fw = frame_cols();
                fh = frame_rows();
                want = '0;
                case (op_t'(s_tuser))
                    OP_FILL:
                        fill_rect(x, y, int'(d[W_LSB +: LEN_W]), int'(d[H_LSB +: LEN_W]),
                                  d[C_LSB +: PIX_W]);
                    OP_COPY:
                        copy_rect($signed(d[SX_LSB +: POS_W]), $signed(d[SY_LSB +: POS_W]),
                                  x, y, int'(d[W_LSB +: LEN_W]), int'(d[H_LSB +: LEN_W]));
                    OP_READ:
                    begin
                        want.is_read = 1'b1;
                        if (x >= 0 && x < fw && y >= 0 && y < fh)
                            want.value = shadow_fb[y*fw + x];
                    end
                    default:
                        if (x >= 0 && x < fw && y >= 0 && y < fh)
                            shadow_fb[y*fw + x] = d[C_LSB +: PIX_W];
                endcase
                result_q.push_back(want);
            end
        end
        errors  <= fail_cnt;
        pending <= result_q.size();
    end

endmodule

// ===== dv/tb_framebuffer_rect_fill_copy_blitter.sv =====
// ----------------------------------------------------------------------------
// tb_framebuffer_rect_fill_copy_blitter: stimulus and verdict for the blitter
// Paints the whole store once, runs directed clip and overlap cases, then
// random fill/copy/read/write traffic over a sweep of frame sizes with random
// idle gaps on the command side and stalls on the result side.
// ----------------------------------------------------------------------------
module tb_framebuffer_rect_fill_copy_blitter;
    import blit_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_PHASES  = 10;
    localparam int PHASE_CMDS = 56;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [OP_W-1:0]      s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [PIX_W-1:0]     m_tdata;
    logic                 m_tuser;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [CFG_W-1:0]     cfg_wdata;
    int                   errors;
    int                   pending;

    bit no_idle;
    int cur_fw;
    int cur_fh;
    int big_left = 12;
    int op_hits[4];

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    framebuffer_rect_fill_copy_blitter DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    blit_result_checker u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .errors    (errors),
        .pending   (pending)
    );

    task automatic send_cmd(input op_t op, input int x, input int y, input int sx,
                            input int sy, input int w, input int h,
                            input logic [PIX_W-1:0] c);
        logic [S_TDATA_W-1:0] d;
        int gap;
        d = '0;
        d[X_LSB +: POS_W]  = x[POS_W-1:0];
        d[Y_LSB +: POS_W]  = y[POS_W-1:0];
        d[SX_LSB +: POS_W] = sx[POS_W-1:0];
        d[SY_LSB +: POS_W] = sy[POS_W-1:0];
        d[W_LSB +: LEN_W]  = w[LEN_W-1:0];
        d[H_LSB +: LEN_W]  = h[LEN_W-1:0];
        d[C_LSB +: PIX_W]  = c;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= op;
        do @(posedge clk); while (!s_tready);
        op_hits[op]++;
    endtask

    // hold commands back until every result beat is home
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic set_frame(input int w, input int h);
        drain();
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_FRAME_WIDTH;
        cfg_wdata <= w[CFG_W-1:0];
        @(posedge clk);
        cfg_addr  <= REG_FRAME_HEIGHT;
        cfg_wdata <= h[CFG_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_fw = (w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : w;
        cur_fh = (h > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : h;
    endtask

    function automatic int rand_s16();
        logic signed [POS_W-1:0] r;
        r = POS_W'($urandom);
        return int'(r);
    endfunction

    // mostly near the frame, now and then anywhere in the 16-bit range
    function automatic int pick_pos(input int lim, input bit hit);
        if ($urandom_range(0, 15) == 0)
            return rand_s16();
        if (hit && lim > 0)
            return $urandom_range(0, lim - 1);
        return int'($urandom_range(0, lim + 7)) - 4;
    endfunction

    task automatic random_cmd();
        op_t op;
        int pick, x, y, sx, sy, w, h;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            op = OP_READ;
        else if (pick < 60)
            op = OP_WRITE;
        else if (pick < 80)
            op = OP_FILL;
        else
            op = OP_COPY;
        if (op == OP_READ || op == OP_WRITE)
        begin
            // rectangle fields are don't-care here, so they carry full-range noise
            x  = pick_pos(cur_fw, $urandom_range(0, 7) != 0);
            y  = pick_pos(cur_fh, $urandom_range(0, 7) != 0);
            sx = rand_s16();
            sy = rand_s16();
            w  = $urandom_range(0, 32767);
            h  = $urandom_range(0, 32767);
        end
        else
        begin
            x = pick_pos(cur_fw, 1'b0);
            y = pick_pos(cur_fh, 1'b0);
            if ($urandom_range(0, 1) == 1)
            begin
                sx = x + int'($urandom_range(0, 6)) - 3;
                sy = y + int'($urandom_range(0, 6)) - 3;
            end
            else
            begin
                sx = pick_pos(cur_fw, 1'b0);
                sy = pick_pos(cur_fh, 1'b0);
            end
            if (big_left > 0 && $urandom_range(0, 19) == 0)
            begin
                big_left--;
                w = $urandom_range(0, 32767);
                h = $urandom_range(0, 32767);
            end
            else
            begin
                w = $urandom_range(0, 12);
                h = $urandom_range(0, 12);
            end
        end
        send_cmd(op, x, y, sx, sy, w, h, $urandom);
    endtask

    initial
    begin : sink
        int stall;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    initial
    begin : stim
        int phase_w[N_PHASES];
        int phase_h[N_PHASES];
        phase_w = '{256, 1, 256, 1, 16, 0, 23, 511, 40, 256};
        phase_h = '{256, 1, 1, 256, 16, 37, 0, 300, 23, 256};
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= OP_FILL;
        cfg_we    <= 1'b0;
        cfg_addr  <= REG_FRAME_WIDTH;
        cfg_wdata <= '0;
        no_idle   <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_frame(256, 256);

        // paint every store entry first so nothing unwritten is ever read or copied
        send_cmd(OP_FILL, 0, 0, 0, 0, 32767, 32767, 32'hFFFF_FFFF);
        send_cmd(OP_FILL, -32768, -32768, 0, 0, 0, 0, 32'h0);
        send_cmd(OP_FILL, 3, 3, 0, 0, 5, 0, 32'hDEAD_BEEF);
        send_cmd(OP_WRITE, 0, 0, 0, 0, 0, 0, 32'h0);
        send_cmd(OP_WRITE, 255, 255, 0, 0, 0, 0, 32'hA5A5_5A5A);
        send_cmd(OP_WRITE, 32767, -32768, 0, 0, 0, 0, 32'h1234_5678);
        send_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 32'h0);
        send_cmd(OP_READ, 255, 255, 0, 0, 0, 0, 32'h0);
        send_cmd(OP_READ, 256, 0, 0, 0, 0, 0, 32'h0);
        send_cmd(OP_READ, -1, 5, 0, 0, 0, 0, 32'h0);
        send_cmd(OP_READ, 32767, 32767, 0, 0, 0, 0, 32'h0);
        send_cmd(OP_READ, -32768, -32768, 0, 0, 0, 0, 32'h0);
        // partly off the left and bottom edges
        send_cmd(OP_FILL, -3, 250, 0, 0, 8, 10, 32'h1357_9BDF);
        send_cmd(OP_READ, 4, 255, 0, 0, 0, 0, 32'h0);
        // overlapping copies in both walk directions, then empty and clipped ones
        send_cmd(OP_COPY, 2, 252, 0, 250, 6, 4, 32'h0);
        send_cmd(OP_COPY, 0, 250, 2, 252, 6, 4, 32'h0);
        send_cmd(OP_COPY, 10, 10, 0, 0, 0, 5, 32'h0);
        send_cmd(OP_COPY, 100, 100, -2, -2, 5, 5, 32'h0);
        send_cmd(OP_COPY, 32767, 32767, 0, 0, 32767, 32767, 32'h0);
        send_cmd(OP_COPY, 0, 0, 250, 0, 32767, 32767, 32'h0);
        send_cmd(OP_READ, 2, 252, 0, 0, 0, 0, 32'h0);
        send_cmd(OP_READ, 101, 101, 0, 0, 0, 0, 32'h0);
        send_cmd(OP_READ, 3, 0, 0, 0, 0, 0, 32'h0);

        for (int p = 0; p < N_PHASES; p++)
        begin
            set_frame(phase_w[p], phase_h[p]);
            no_idle <= (p % 3 == 2);
            for (int n = 0; n < PHASE_CMDS; n++)
            begin
                if ($urandom_range(0, 15) == 0)
                    no_idle <= !no_idle;
                if ($urandom_range(0, 39) == 0)
                    drain();
                random_cmd();
            end
        end

        drain();
        repeat (20) @(posedge clk);
        $display("Ran %0d commands: %0d fill, %0d copy, %0d read, %0d write",
                 op_hits[OP_FILL] + op_hits[OP_COPY] + op_hits[OP_READ] + op_hits[OP_WRITE],
                 op_hits[OP_FILL], op_hits[OP_COPY], op_hits[OP_READ], op_hits[OP_WRITE]);
        $display("Frame sizes swept: %0d, incl. single-pixel, empty and oversized", N_PHASES);
        if (errors == 0 && pending == 0)
            $display("** framebuffer_rect_fill_copy_blitter: PASSED **");
        else
            $display("** framebuffer_rect_fill_copy_blitter: FAILED **");
        $finish;
    end

    initial
    begin : watchdog
        #60_000_000;
        $display("** framebuffer_rect_fill_copy_blitter: FAILED **");
        $finish;
    end

endmodule
